// ===== rtl/core/alert_gated_event_counter_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the alert-gated event counter
// Immediate-consequence and next-cycle checks, removed under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ALERT_GATED_EVENT_COUNTER_MACROS_SVH
`define ALERT_GATED_EVENT_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define AGEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("agec check failed");
// Check cons in the cycle after ante.
`define AGEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("agec check failed");
`else
`define AGEC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define AGEC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/agec_pkg.sv =====
// ---------------------------------------------------------------------------
// agec_pkg
// Shared types and reset constants of the alert-gated event counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package agec_pkg;

	localparam int COUNT_W  = 17;
	localparam int TEMP_W   = 16;
	localparam int PRESC_W  = 8;
	localparam int HOLD_W   = 16;
	localparam int SRC_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_TEMP  = 2'd1,
		ACT_IRQ   = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_COUNTING   = 2'd0,
		MODE_TEMP_ALERT = 2'd1,
		MODE_EXT_ALERT  = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_THRESHOLD = 2'd0,
		REG_TICKS_PER_WORK = 2'd1,
		REG_COUNT_LIMIT    = 2'd2,
		REG_ALERT_HOLD     = 2'd3
	} reg_idx_t;

	localparam logic [SRC_W-1:0] ALERT_SOURCE = 3'd1;

	localparam logic signed [TEMP_W-1:0] RST_TEMP_THRESHOLD = 16'sd250;
	localparam logic [PRESC_W-1:0]       RST_TICKS_PER_WORK = 8'd50;
	localparam logic [COUNT_W-1:0]       RST_COUNT_LIMIT    = 17'd100000;
	localparam logic [HOLD_W-1:0]        RST_ALERT_HOLD     = 16'd50;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_threshold;
		logic [PRESC_W-1:0]       ticks_per_work_tick;
		logic [COUNT_W-1:0]       count_limit;
		logic [HOLD_W-1:0]        alert_hold_ticks;
	} cfg_t;

	typedef struct packed {
		action_t                  action;
		logic signed [TEMP_W-1:0] temperature;
		logic [SRC_W-1:0]         int_source;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]       count;
		mode_t                    mode;
		logic                     refresh;
		logic signed [TEMP_W-1:0] last_temperature;
	} result_t;

endpackage

// ===== rtl/core/agec_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// agec_cfg_regs
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module agec_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [agec_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [agec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output agec_pkg::cfg_t                   cfg
);
	import agec_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_threshold      <= RST_TEMP_THRESHOLD;
			cfg_q.ticks_per_work_tick <= RST_TICKS_PER_WORK;
			cfg_q.count_limit         <= RST_COUNT_LIMIT;
			cfg_q.alert_hold_ticks    <= RST_ALERT_HOLD;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TEMP_THRESHOLD: cfg_q.temp_threshold      <= cfg_wdata[TEMP_W-1:0];
				REG_TICKS_PER_WORK: cfg_q.ticks_per_work_tick <= cfg_wdata[PRESC_W-1:0];
				REG_COUNT_LIMIT:    cfg_q.count_limit         <= cfg_wdata[COUNT_W-1:0];
				REG_ALERT_HOLD:     cfg_q.alert_hold_ticks    <= cfg_wdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/agec_engine.sv =====
// ---------------------------------------------------------------------------
// agec_engine
// Counter, mode and hold-timer state with the single-pass update logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module agec_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  agec_pkg::item_t   item,
	input  agec_pkg::cfg_t    cfg,
	output agec_pkg::result_t result
);
	import agec_pkg::*;

	logic [PRESC_W-1:0]       presc_q, presc_d;
	logic [COUNT_W-1:0]       count_q, count_d;
	mode_t                    mode_q, mode_d;
	logic [HOLD_W-1:0]        hold_q, hold_d;
	logic signed [TEMP_W-1:0] temp_q, temp_d;
	logic                     refresh;

	logic [PRESC_W:0]   presc_inc;
	logic               work_tick;
	logic [COUNT_W:0]   count_inc;
	logic [HOLD_W-1:0]  hold_dec;

	assign presc_inc = {1'b0, presc_q} + {{PRESC_W{1'b0}}, 1'b1};
	assign work_tick = presc_inc >= {1'b0, cfg.ticks_per_work_tick};
	assign count_inc = {1'b0, count_q} + {{COUNT_W{1'b0}}, 1'b1};
	assign hold_dec  = hold_q - {{(HOLD_W-1){1'b0}}, 1'b1};

	always_comb begin
		presc_d = presc_q;
		count_d = count_q;
		mode_d  = mode_q;
		hold_d  = hold_q;
		temp_d  = temp_q;
		refresh = 1'b0;
		case (item.action)
			ACT_TICK: begin
				presc_d = work_tick ? '0 : presc_inc[PRESC_W-1:0];
				if (work_tick) begin
					if (mode_q == MODE_COUNTING) begin
						// wrap once past the limit
						count_d = (count_inc > {1'b0, cfg.count_limit}) ? '0
							: count_inc[COUNT_W-1:0];
						refresh = 1'b1;
					end else if (mode_q == MODE_EXT_ALERT && hold_q != '0) begin
						hold_d = hold_dec;
						if (hold_dec == '0) begin
							mode_d  = MODE_COUNTING;
							refresh = 1'b1;
						end
					end
				end
			end
			ACT_TEMP: begin
				temp_d = item.temperature;
				if (item.temperature > cfg.temp_threshold) begin
					mode_d  = MODE_TEMP_ALERT;
					refresh = 1'b1;
				end else if (mode_q == MODE_TEMP_ALERT) begin
					mode_d  = MODE_COUNTING;
					refresh = 1'b1;
				end
			end
			ACT_IRQ: begin
				if (item.int_source == ALERT_SOURCE) begin
					mode_d  = MODE_EXT_ALERT;
					hold_d  = cfg.alert_hold_ticks;
					refresh = 1'b1;
				end
			end
			ACT_CLEAR: begin
				count_d = '0;
				refresh = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q <= '0;
			count_q <= '0;
			mode_q  <= MODE_COUNTING;
			hold_q  <= '0;
			temp_q  <= '0;
		end else if (fire) begin
			presc_q <= presc_d;
			count_q <= count_d;
			mode_q  <= mode_d;
			hold_q  <= hold_d;
			temp_q  <= temp_d;
		end
	end

	assign result.count            = count_d;
	assign result.mode             = mode_d;
	assign result.refresh          = refresh;
	assign result.last_temperature = temp_d;

endmodule

// ===== rtl/core/alert_gated_event_counter.sv =====
// ---------------------------------------------------------------------------
// alert_gated_event_counter
// Prescaled event counter gated by temperature and external-interrupt alerts.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_*       in         tuser: action[1:0]; tdata: temperature[15:0],
//                       int_source[18:16], zero pad[23:19]
//  m_*       out        tdata: count[16:0], mode[18:17], refresh[19],
//                       last_temperature[35:20], zero pad[39:36]
//  cfg_*     in         register write: index, data, write enable
//
//  Every beat yields exactly one result beat. An accepted beat sits in the
//  input register until the engine updates its state; the result register
//  loads in the same edge. One beat per cycle is sustained while m_tready
//  stays high. The rate is set by the single-pass state update in the engine.
//  A stall on m_tready holds the result register and then the input register;
//  s_tready drops only when both are full. Reset clears all state, restores
//  the register defaults and empties both stages.
//
`timescale 1ns / 1ps

`include "alert_gated_event_counter_macros.svh"

module alert_gated_event_counter (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave side
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [agec_pkg::IN_DATA_W-1:0]    s_tdata,  // temperature, int_source
	input  logic [1:0]                        s_tuser,  // action
	// master side
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [agec_pkg::OUT_DATA_W-1:0]   m_tdata,  // count, mode, refresh, last_temperature
	// configuration
	input  logic                              cfg_we,
	input  logic [agec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [agec_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import agec_pkg::*;

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_q;
	logic    out_valid_q;
	logic    adv_s1;
	logic    in_fire;

	// Unpack the incoming beat.
	assign item_in.action      = action_t'(s_tuser);
	assign item_in.temperature = s_tdata[TEMP_W-1:0];
	assign item_in.int_source  = s_tdata[TEMP_W+SRC_W-1:TEMP_W];

	// Advance the input stage whenever the result register is free or draining.
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign in_fire  = s_tvalid && s_tready;

	agec_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	agec_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Input register: hold the beat until the engine takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= item_in;
		end
	end

	// Result register: load on engine update, drop when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-COUNT_W-2-1-TEMP_W){1'b0}},
		result_q.last_temperature, result_q.refresh, result_q.mode, result_q.count};

	// A stalled result must stay in place.
	`AGEC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && !m_tready, out_valid_q)
	// A beat in the input stage that cannot advance must not be lost.
	`AGEC_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv_s1, valid_s1)
	// Every engine update produces a result beat.
	`AGEC_ASSERT_NEXT(a_adv_out, clk, arst_n, adv_s1, out_valid_q)
	// Both stages full and stalled: no new beat may enter.
	`AGEC_ASSERT_NOW(a_no_overrun, clk, arst_n, valid_s1 && out_valid_q && !m_tready, !s_tready)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the alert-gated event counter: a directed table of
// beats and register writes, then random phases with fresh register settings,
// all predicted cycle-free by a behavioral copy of the counter (or, for some
// table rows, typed in) and compared beat by beat on the result stream.
// ---------------------------------------------------------------------------

module testbench;

	import agec_pkg::*;

	// Row kinds of the directed table: a beat checked by the predictor, a beat
	// whose result is typed into the table, or a register write.
	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_KNOWN,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		item_t                 in;
		result_t               known;
		reg_idx_t              idx;
		logic [CFG_DATA_W-1:0] val;
	} dir_row_t;

	localparam int NUM_PHASES     = 10;
	localparam int BEATS_PER_PHASE = 85;
	localparam int DRAIN_CYCLES   = 4;   // two pipeline stages plus margin
	localparam int RX_HOLD_CYCLES = 80;
	localparam int STALL_LIMIT    = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // temperature[15:0], int_source[18:16], zero pad
	logic [1:0]            s_tuser;   // action[1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // count, mode, refresh, last_temperature, zero pad
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Register shadows, kept in step with every write
	logic signed [TEMP_W-1:0] thr_cfg;
	logic [PRESC_W-1:0]       tpw_cfg;
	logic [COUNT_W-1:0]       limit_cfg;
	logic [HOLD_W-1:0]        hold_cfg;

	// Counter state as the block should hold it
	logic [PRESC_W-1:0]       prescale_q;
	logic [COUNT_W-1:0]       count_q;
	mode_t                    mode_q;
	logic [HOLD_W-1:0]        hold_q;
	logic signed [TEMP_W-1:0] seen_temp_q;

	result_t  display_expected[$];
	dir_row_t dir_rows[$];

	int errors;
	int tx_idle_pct;
	int rx_idle_pct;
	bit rx_hold_req;
	int rx_hold_left;
	int quiet_cycles;

	alert_gated_event_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the counter by one beat and return what the display should show.
	function automatic result_t advance_counter(item_t it);
		result_t          r;
		logic [PRESC_W:0] pre_next;
		logic [COUNT_W:0] count_next;
		logic             refresh;
		refresh = 1'b0;
		case (it.action)
			ACT_TICK: begin
				pre_next = {1'b0, prescale_q} + 1'b1;
				if (pre_next >= {1'b0, tpw_cfg}) begin
					// work tick: count, or run down the external hold
					prescale_q = '0;
					if (mode_q == MODE_COUNTING) begin
						count_next = {1'b0, count_q} + 1'b1;
						count_q = (count_next > {1'b0, limit_cfg}) ? '0 : count_next[COUNT_W-1:0];
						refresh = 1'b1;
					end else if (mode_q == MODE_EXT_ALERT && hold_q != '0) begin
						hold_q = hold_q - 1'b1;
						if (hold_q == '0) begin
							mode_q = MODE_COUNTING;
							refresh = 1'b1;
						end
					end
				end else begin
					prescale_q = pre_next[PRESC_W-1:0];
				end
			end
			ACT_TEMP: begin
				seen_temp_q = it.temperature;
				if (it.temperature > thr_cfg) begin
					mode_q = MODE_TEMP_ALERT;
					refresh = 1'b1;
				end else if (mode_q == MODE_TEMP_ALERT) begin
					mode_q = MODE_COUNTING;
					refresh = 1'b1;
				end
			end
			ACT_IRQ: begin
				if (it.int_source == ALERT_SOURCE) begin
					mode_q = MODE_EXT_ALERT;
					hold_q = hold_cfg;
					refresh = 1'b1;
				end
			end
			default: begin
				count_q = '0;
				refresh = 1'b1;
			end
		endcase
		r.count = count_q;
		r.mode = mode_q;
		r.refresh = refresh;
		r.last_temperature = seen_temp_q;
		return r;
	endfunction

	function automatic dir_row_t row_item(action_t a, logic signed [TEMP_W-1:0] t,
			logic [SRC_W-1:0] s);
		dir_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.in.action = a;
		r.in.temperature = t;
		r.in.int_source = s;
		return r;
	endfunction

	function automatic dir_row_t row_known(action_t a, logic signed [TEMP_W-1:0] t,
			logic [SRC_W-1:0] s, logic [COUNT_W-1:0] c, mode_t m, logic f,
			logic signed [TEMP_W-1:0] lt);
		dir_row_t r;
		r = row_item(a, t, s);
		r.kind = ROW_KNOWN;
		r.known.count = c;
		r.known.mode = m;
		r.known.refresh = f;
		r.known.last_temperature = lt;
		return r;
	endfunction

	function automatic dir_row_t row_cfg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	// Offer one beat, with random gaps ahead of it; return at the accepting edge
	// without touching tvalid, so a following beat can keep it high.
	task automatic send_item(item_t it, bit use_known, result_t known);
		result_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_DATA_W - TEMP_W - SRC_W){1'b0}}, it.int_source, it.temperature};
		s_tuser  <= it.action;
		do @(posedge clk); while (!s_tready);
		predicted = advance_counter(it);
		display_expected.push_back(use_known ? known : predicted);
	endtask

	// Drop tvalid, wait out every pending result, then let the pipeline empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (display_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TEMP_THRESHOLD: thr_cfg   = val[TEMP_W-1:0];
			REG_TICKS_PER_WORK: tpw_cfg   = val[PRESC_W-1:0];
			REG_COUNT_LIMIT:    limit_cfg = val[COUNT_W-1:0];
			REG_ALERT_HOLD:     hold_cfg  = val[HOLD_W-1:0];
			default: ;
		endcase
	endtask

	// Result side: check each accepted beat against the oldest expectation,
	// then pick tready for the next cycle. A hold-off request forces a long
	// run of tready low, counted here.
	always @(posedge clk) begin : rx_side
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.count = m_tdata[COUNT_W-1:0];
			got.mode = mode_t'(m_tdata[COUNT_W+1:COUNT_W]);
			got.refresh = m_tdata[COUNT_W+2];
			got.last_temperature = m_tdata[COUNT_W+3+TEMP_W-1:COUNT_W+3];
			if (display_expected.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected: expected none, actual %h",
					$time, m_tdata);
			end else begin
				want = display_expected.pop_front();
				if (got.count !== want.count) begin
					errors++;
					$display("%0t: count mismatch: expected %0d, actual %0d",
						$time, want.count, got.count);
				end
				if (got.mode !== want.mode) begin
					errors++;
					$display("%0t: mode mismatch: expected %0d, actual %0d",
						$time, want.mode, got.mode);
				end
				if (got.refresh !== want.refresh) begin
					errors++;
					$display("%0t: refresh mismatch: expected %0d, actual %0d",
						$time, want.refresh, got.refresh);
				end
				if (got.last_temperature !== want.last_temperature) begin
					errors++;
					$display("%0t: last_temperature mismatch: expected %0d, actual %0d",
						$time, want.last_temperature, got.last_temperature);
				end
			end
		end
		if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_hold_left = RX_HOLD_CYCLES;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin : stimulus
		item_t                 it;
		result_t               none;
		int                    r;
		logic signed [TEMP_W-1:0] thr_pick;
		logic [PRESC_W-1:0]    tpw_pick;
		logic [COUNT_W-1:0]    limit_pick;
		logic [HOLD_W-1:0]     hold_pick;

		// Drive every input to a known value before the first edge.
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_TICK;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TEMP_THRESHOLD;
		cfg_wdata = '0;
		errors = 0;
		quiet_cycles = 0;
		rx_hold_req = 1'b0;
		rx_hold_left = 0;
		none = '0;

		thr_cfg = RST_TEMP_THRESHOLD;
		tpw_cfg = RST_TICKS_PER_WORK;
		limit_cfg = RST_COUNT_LIMIT;
		hold_cfg = RST_ALERT_HOLD;
		prescale_q = '0;
		count_q = '0;
		mode_q = MODE_COUNTING;
		hold_q = '0;
		seen_temp_q = '0;

		tx_idle_pct = 6;
		rx_idle_pct = 77;

		dir_rows = '{
			// defaults after reset: threshold 250, hold 50
			row_known(ACT_TEMP, 16'sd0, 3'd0, 17'd0, MODE_COUNTING, 1'b0, 16'sd0),
			row_known(ACT_TEMP, 16'sd251, 3'd0, 17'd0, MODE_TEMP_ALERT, 1'b1, 16'sd251),
			// at the threshold: back to counting from temperature alert
			row_known(ACT_TEMP, 16'sd250, 3'd0, 17'd0, MODE_COUNTING, 1'b1, 16'sd250),
			row_known(ACT_TEMP, -16'sd32768, 3'd0, 17'd0, MODE_COUNTING, 1'b0, -16'sd32768),
			row_known(ACT_TEMP, 16'sd32767, 3'd0, 17'd0, MODE_TEMP_ALERT, 1'b1, 16'sd32767),
			row_known(ACT_IRQ, 16'sd0, 3'd1, 17'd0, MODE_EXT_ALERT, 1'b1, 16'sd32767),
			// a cool sample does not end an external alert
			row_known(ACT_TEMP, 16'sd0, 3'd0, 17'd0, MODE_EXT_ALERT, 1'b0, 16'sd0),
			row_known(ACT_IRQ, -16'sd1, 3'd7, 17'd0, MODE_EXT_ALERT, 1'b0, 16'sd0),
			row_known(ACT_IRQ, 16'sd0, 3'd0, 17'd0, MODE_EXT_ALERT, 1'b0, 16'sd0),
			row_item(ACT_TICK, 16'sd0, 3'd0),
			row_known(ACT_CLEAR, 16'sd0, 3'd0, 17'd0, MODE_EXT_ALERT, 1'b1, 16'sd0),
			// zero prescale, short hold, limit of one
			row_cfg(REG_TICKS_PER_WORK, 17'd0),
			row_cfg(REG_ALERT_HOLD, 17'd2),
			row_cfg(REG_COUNT_LIMIT, 17'd1),
			row_item(ACT_IRQ, 16'sd0, 3'd1),
			row_item(ACT_TICK, 16'sd0, 3'd0),
			row_item(ACT_TICK, 16'sd0, 3'd0),
			row_item(ACT_TICK, 16'sd0, 3'd0),
			row_item(ACT_TICK, 16'sd0, 3'd0),
			// zero hold, the lowest threshold and the top count limit
			row_cfg(REG_ALERT_HOLD, 17'd0),
			row_cfg(REG_TEMP_THRESHOLD, {1'b0, 16'h8000}),
			row_cfg(REG_COUNT_LIMIT, 17'h1FFFF),
			row_item(ACT_IRQ, 16'sd0, 3'd1),
			row_item(ACT_TICK, 16'sd0, 3'd0),
			row_item(ACT_TEMP, -16'sd32768, 3'd0),
			row_item(ACT_TEMP, -16'sd32767, 3'd0),
			// top of every register
			row_cfg(REG_TEMP_THRESHOLD, {1'b0, 16'h7FFF}),
			row_cfg(REG_TICKS_PER_WORK, 17'd255),
			row_cfg(REG_ALERT_HOLD, 17'd65535),
			row_item(ACT_TEMP, 16'sd32767, 3'd0),
			row_item(ACT_TICK, 16'sd0, 3'd0),
			row_item(ACT_IRQ, 16'sd0, 3'd1),
			row_item(ACT_CLEAR, 16'sd0, 3'd0)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_item(dir_rows[i].in, dir_rows[i].kind == ROW_KNOWN, dir_rows[i].known);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			// Pause until every result is in, then load new settings.
			settle();
			case (p)
				1: begin
					thr_pick = 16'sh7FFF;
					tpw_pick = 8'd255;
					limit_pick = 17'h1FFFF;
					hold_pick = 16'hFFFF;
				end
				2: begin
					// leaves a prescale count above the new period: next tick works
					thr_pick = 16'sh8000;
					tpw_pick = 8'd1;
					limit_pick = '0;
					hold_pick = '0;
				end
				default: begin
					thr_pick = 16'($urandom_range(600)) - 16'd300;
					tpw_pick = 8'($urandom_range(4));
					limit_pick = 17'($urandom_range(30));
					hold_pick = 16'($urandom_range(6));
				end
			endcase
			write_reg(REG_TEMP_THRESHOLD, {1'b0, thr_pick});
			write_reg(REG_TICKS_PER_WORK, {9'd0, tpw_pick});
			write_reg(REG_COUNT_LIMIT, limit_pick);
			write_reg(REG_ALERT_HOLD, {1'b0, hold_pick});

			if (p < 4) begin
				tx_idle_pct = 6;
				rx_idle_pct = 77;
			end else if (p < 7) begin
				tx_idle_pct = 77;
				rx_idle_pct = 6;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// Hold the result side off while beats keep coming, to back up the input.
			if (p == 7)
				rx_hold_req = 1'b1;

			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				r = $urandom_range(99);
				if (r < 50)
					it.action = ACT_TICK;
				else if (r < 70)
					it.action = ACT_TEMP;
				else if (r < 88)
					it.action = ACT_IRQ;
				else
					it.action = ACT_CLEAR;
				if ($urandom_range(1))
					it.temperature = thr_cfg - 16'sd2 + 16'($urandom_range(4));
				else
					it.temperature = 16'($urandom);
				it.int_source = $urandom_range(1) ? ALERT_SOURCE : 3'($urandom_range(7));
				send_item(it, 1'b0, none);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== alert_gated_event_counter.f =====
+incdir+rtl/core
rtl/core/agec_pkg.sv
rtl/core/agec_cfg_regs.sv
rtl/core/agec_engine.sv
rtl/core/alert_gated_event_counter.sv
dv/testbench.sv
